>>> rtl/assert_macros.svh
// Assertion macros shared by the sort block's RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define DSS_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define DSS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DSS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/dss_pkg.sv
// Shared types and constants of the descending selection sort block.
package dss_pkg;

   localparam int KEY_W = 16;
   localparam int TAG_W = 8;

   // One stored record: key in the upper bits, tag below.
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } dss_rec_type;

   localparam int REC_W = $bits(dss_rec_type);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_START,
      ST_SCAN,
      ST_SWAP_A,
      ST_SWAP_B
   } dss_state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;
      logic scan_start;
      logic scan_step;
      logic swap_a;
      logic swap_b;
   } dss_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic last_in;
      logic scan_done;
      logic pass_last;
      logic out_free;
   } dss_status_type;

endpackage

>>> rtl/dss_req_if.sv
// Input channel: one unsorted record per item.
interface dss_req_if import dss_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] sort_key;
   logic [TAG_W-1:0] record_tag;
   logic             last_record;

   modport source (output valid, sort_key, record_tag, last_record, input ready);
   modport sink   (input valid, sort_key, record_tag, last_record, output ready);
endinterface

>>> rtl/dss_rsp_if.sv
// Result channel: one sorted record per item.
interface dss_rsp_if import dss_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] sorted_key;
   logic [TAG_W-1:0] sorted_tag;
   logic             end_of_run;
   logic             overflowed;

   modport source (output valid, sorted_key, sorted_tag, end_of_run, overflowed, input ready);
   modport sink   (input valid, sorted_key, sorted_tag, end_of_run, overflowed, output ready);
endinterface

>>> rtl/dss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dss_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry, both on the clock
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/dss_ctrl.sv
// Sequencer for loading, scanning, swapping and emitting records.
module dss_ctrl import dss_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  dss_status_type status,
   output dss_cmd_type    cmd
);

   dss_state_type state_ff;
   dss_state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (status.last_in) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_SWAP_A;
            end
         end
         ST_SWAP_A: begin
            state_in = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            if (status.out_free) begin
               state_in = status.pass_last ? ST_LOAD : ST_START;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Commands per state
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_LOAD:   cmd.load       = 1'b1;
         ST_START:  cmd.scan_start = 1'b1;
         ST_SCAN:   cmd.scan_step  = 1'b1;
         ST_SWAP_A: cmd.swap_a     = 1'b1;
         ST_SWAP_B: cmd.swap_b     = 1'b1;
         default:   cmd            = '0;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/dss_datapath.sv
// Record store, pass scanner, swap writes and output register.
`include "assert_macros.svh"

module dss_datapath import dss_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  logic           clock,
   input  logic           reset,
   dss_req_if.sink        req_ch,
   dss_rsp_if.source      rsp_ch,
   input  dss_cmd_type    cmd,
   output dss_status_type status
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic             first_ff, first_in;
   dss_rec_type      best_ff, best_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   dss_rec_type      pos_rec_ff, pos_rec_in;
   dss_rec_type      out_rec_ff, out_rec_in;
   logic             out_eor_ff, out_eor_in;
   logic             out_ovf_ff, out_ovf_in;
   logic             out_valid_ff, out_valid_in;

   logic             accept;
   logic             full;
   logic             out_free;
   logic             emit;
   logic             pass_last;
   logic             scan_done;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   dss_rec_type      wr_rec;
   logic [IDX_W-1:0] rd_addr;
   dss_rec_type      rd_rec;
   logic [REC_W-1:0] rd_data;

   // Handshake and status terms
   assign accept    = cmd.load && req_ch.valid;
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign out_free  = !out_valid_ff || rsp_ch.ready;
   assign emit      = cmd.swap_b && out_free;
   assign pass_last = ((CNT_W'(pos_ff) + CNT_W'(1)) == count_ff);
   assign scan_done = ((CNT_W'(addr_ff) + CNT_W'(1)) == count_ff);
   assign rd_rec    = dss_rec_type'(rd_data);

   assign req_ch.ready = cmd.load;

   assign status.last_in   = accept && req_ch.last_record;
   assign status.scan_done = scan_done;
   assign status.pass_last = pass_last;
   assign status.out_free  = out_free;

   // Select the RAM write: load, then the two halves of a swap
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = count_ff[IDX_W-1:0];
      wr_rec  = '{key: req_ch.sort_key, tag: req_ch.record_tag};
      if (accept && !full) begin
         wr_en = 1'b1;
      end else if (cmd.swap_a) begin
         wr_en   = 1'b1;
         wr_addr = best_idx_ff;
         wr_rec  = pos_rec_ff;
      end else if (emit) begin
         wr_en   = 1'b1;
         wr_addr = pos_ff;
         wr_rec  = best_ff;
      end
   end

   // Read the pass head on start, then walk forward one entry a cycle
   assign rd_addr = cmd.scan_start ? pos_ff : (addr_ff + IDX_W'(1));

   dss_ram #(
      .WIDTH (REC_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rec),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Count records, flag drops and advance the pass position; clear all three once a run is emitted
   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      pos_in   = pos_ff;
      if (accept) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (emit) begin
         if (pass_last) begin
            count_in = '0;
            ovf_in   = 1'b0;
            pos_in   = '0;
         end else begin
            pos_in = pos_ff + IDX_W'(1);
         end
      end
   end

   // Track the first strictly greatest key of the pass
   always_comb begin
      addr_in     = addr_ff;
      first_in    = first_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      pos_rec_in  = pos_rec_ff;
      if (cmd.scan_start) begin
         addr_in  = pos_ff;
         first_in = 1'b1;
      end else if (cmd.scan_step) begin
         addr_in  = addr_ff + IDX_W'(1);
         first_in = 1'b0;
         if (first_ff) begin
            best_in     = rd_rec;
            best_idx_in = addr_ff;
            pos_rec_in  = rd_rec;
         end else if (rd_rec.key > best_ff.key) begin
            best_in     = rd_rec;
            best_idx_in = addr_ff;
         end
      end
   end

   // Hold the result until taken; load the pass winner on emit
   always_comb begin
      out_valid_in = out_valid_ff;
      out_rec_in   = out_rec_ff;
      out_eor_in   = out_eor_ff;
      out_ovf_in   = out_ovf_ff;
      if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         out_rec_in   = best_ff;
         out_eor_in   = pass_last;
         out_ovf_in   = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         pos_ff       <= '0;
         first_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         pos_ff       <= pos_in;
         first_ff     <= first_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      pos_rec_ff  <= pos_rec_in;
      out_rec_ff  <= out_rec_in;
      out_eor_ff  <= out_eor_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.sorted_key = out_rec_ff.key;
   assign rsp_ch.sorted_tag = out_rec_ff.tag;
   assign rsp_ch.end_of_run = out_eor_ff;
   assign rsp_ch.overflowed = out_ovf_ff;

   `DSS_ASSERT_ALWAYS(a_count_in_range, clock, reset, count_ff <= CNT_W'(CAPACITY), "record count above capacity")
   `DSS_ASSERT_IMPLY(a_scan_in_set, clock, reset, cmd.scan_step, CNT_W'(addr_ff) < count_ff, "scan beyond stored records")
   `DSS_ASSERT_IMPLY(a_pass_in_set, clock, reset, cmd.scan_start, CNT_W'(pos_ff) < count_ff, "pass starts beyond stored records")
   `DSS_ASSERT_NEXT(a_emit_shows, clock, reset, emit, out_valid_ff, "emitted record not presented")

endmodule

>>> rtl/descending_selection_sort.sv
// Top level of the descending selection sort block.
//
//   channel  | dir | payload                                        | accepted when
//   req_ch   | in  | sort_key, record_tag, last_record              | valid && ready
//   rsp_ch   | out | sorted_key, sorted_tag, end_of_run, overflowed | valid && ready
//
// Loading accepts one record per cycle while valid is high; ready is low from the last
// record until the final pass hands its winner to the output register.
// Each pass runs a start state, then a scan with one RAM read per scanned entry, then two
// swap writes. Each pass emits its winner; a stalled result holds the sequencer in the
// second swap write. Reset is synchronous; the record store itself is not cleared.
module descending_selection_sort import dss_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input logic       clock,
   input logic       reset,
   dss_req_if.sink   req_ch,
   dss_rsp_if.source rsp_ch
);

   dss_cmd_type    cmd;
   dss_status_type status;

   dss_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   dss_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cmd    (cmd),
      .status (status)
   );

endmodule
